/* rtl/b64d_pkg.sv */
// Shared types and character decode for the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned HoldW  = 3 * SextW;
  localparam int unsigned GroupW = 4 * SextW;

  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [5:0] SextPlus  = 6'd62;
  localparam logic [5:0] SextSlash = 6'd63;

  // One queue entry: the results that one input character causes.
  typedef struct packed {
    logic [GroupW-1:0] bytes;     // byte 0 in the top bits
    logic [1:0]        last_idx;  // index of the final result, 0..2
    logic              has_bytes; // 0: single result without a byte
    logic              eot;       // message ends with this entry
    logic              stop;      // decoding was halted in this message
  } grp_rec_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [CharW-1:0] ch);
    sextet_t     r;
    logic [7:0]  d;
    r = '{ok: 1'b1, value: '0};
    d = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      d = ch - 8'h41;
      r.value = d[5:0];
    end else if (ch inside {[8'h61:8'h7A]}) begin
      d = ch - 8'h47;
      r.value = d[5:0];
    end else if (ch inside {[8'h30:8'h39]}) begin
      d = ch + 8'h04;
      r.value = d[5:0];
    end else if (ch == ChrPlus) begin
      r.value = SextPlus;
    end else if (ch == ChrSlash) begin
      r.value = SextSlash;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/b64d_front.sv */
// Front end: classify each character, pack sextets, emit group records.
module b64d_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              char_code,
  input  logic                    end_of_text,
  output logic                    rec_push,
  output b64d_pkg::grp_rec_t      rec
);

  logic [b64d_pkg::HoldW-1:0] hold_r, hold_nxt;
  logic [1:0]                 count_r, count_nxt;
  logic                       halted_r, halted_nxt;

  b64d_pkg::sextet_t          sx;
  logic [b64d_pkg::HoldW-1:0] hold_upd;
  logic [1:0]                 count_upd;
  logic                       halted_upd;
  logic                       group_done;

  assign sx = b64d_pkg::sextet_of(char_code);

  always_comb begin
    hold_upd   = hold_r;
    count_upd  = count_r;
    halted_upd = halted_r;
    group_done = 1'b0;
    if (!halted_r) begin
      if (!sx.ok) begin
        halted_upd = 1'b1;
      end else if (count_r == 2'd3) begin
        group_done = 1'b1;
        hold_upd   = '0;
        count_upd  = '0;
      end else begin
        hold_upd  = {hold_r[b64d_pkg::HoldW-b64d_pkg::SextW-1:0], sx.value};
        count_upd = count_r + 2'd1;
      end
    end
  end

  always_comb begin
    rec           = '0;
    rec.eot       = end_of_text;
    rec.stop      = end_of_text & halted_upd;
    rec.has_bytes = 1'b1;
    rec_push      = 1'b0;
    if (group_done) begin
      rec.bytes    = {hold_r, sx.value};
      rec.last_idx = 2'd2;
      rec_push     = accept;
    end else if (end_of_text) begin
      rec_push = accept;
      case (count_upd)
        2'd2: begin
          rec.bytes    = {hold_upd[11:4], 16'h0000};
          rec.last_idx = 2'd0;
        end
        2'd3: begin
          rec.bytes    = {hold_upd[17:2], 8'h00};
          rec.last_idx = 2'd1;
        end
        default: begin
          rec.has_bytes = 1'b0;
          rec.last_idx  = 2'd0;
        end
      endcase
    end
  end

  // Clear everything after the last character of a message.
  always_comb begin
    hold_nxt   = hold_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    if (accept) begin
      if (end_of_text) begin
        hold_nxt   = '0;
        count_nxt  = '0;
        halted_nxt = 1'b0;
      end else begin
        hold_nxt   = hold_upd;
        count_nxt  = count_upd;
        halted_nxt = halted_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else begin
      hold_r   <= hold_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// Short record queue between the front end and the result sequencer.
module b64d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  b64d_pkg::grp_rec_t wr_rec,
  output logic               full,
  input  logic               rd_en,
  output b64d_pkg::grp_rec_t rd_rec,
  output logic               empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  b64d_pkg::grp_rec_t slot_r [DEPTH];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full   = (cnt_r == CntW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en & ~full;
  assign do_rd  = rd_en & ~empty;
  assign rd_rec = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
    if (do_rd) rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wptr_r] <= wr_rec;
  end

endmodule

/* rtl/b64d_back.sv */
// Result sequencer: unpack group records into single-byte results.
module b64d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b64d_pkg::grp_rec_t rec,
  input  logic               rec_empty,
  output logic               rec_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         data_byte,
  output logic               byte_valid,
  output logic               end_of_data,
  output logic               stopped_early
);

  logic       out_vld_r, out_vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       bval_r, end_r, stop_r;
  logic       load;
  logic       rec_last;
  logic [7:0] sel_byte;

  assign load     = ~rec_empty & (~out_vld_r | pop);
  assign rec_last = (idx_r == rec.last_idx);
  assign rec_pop  = load & rec_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = rec.bytes[23:16];
      2'd1:    sel_byte = rec.bytes[15:8];
      default: sel_byte = rec.bytes[7:0];
    endcase
    if (!rec.has_bytes) sel_byte = '0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    idx_nxt     = idx_r;
    if (load) begin
      out_vld_nxt = 1'b1;
      idx_nxt     = rec_last ? 2'd0 : idx_r + 2'd1;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      bval_r <= rec.has_bytes;
      end_r  <= rec_last & rec.eot;
      stop_r <= rec_last & rec.stop;
    end
  end

  assign empty         = ~out_vld_r;
  assign data_byte     = byte_r;
  assign byte_valid    = bval_r;
  assign end_of_data   = end_r;
  assign stopped_early = stop_r;

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the base64 stream decoder.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  input    | push / full               | in_char_code[7:0], in_end_of_text
//  result   | empty / pop               | out_data_byte[7:0], out_byte_valid,
//           |                           | out_end_of_data, out_stopped_early
//
// One character is taken per cycle while the record queue has room; each
// character yields 0 to 3 results, and results leave at one per cycle while
// pop is held. A result reaches the out_ ports through the queue: the record
// enters the queue when its character is accepted and moves into the output
// register once that register is empty or being popped. Reset (rst_n low,
// synchronous) clears the sextet packer, the queue and the output valid flag;
// the output data register is not reset. A stall on pop fills the queue,
// which then raises full; input stalls never block results.
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4  // group records in flight, 1 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_data,
  output logic       out_stopped_early
);

  b64d_pkg::grp_rec_t wr_rec, rd_rec;
  logic               accept;
  logic               rec_push;
  logic               rec_pop;
  logic               q_empty;

  // Take a character whenever the queue can hold whatever it produces.
  assign accept = push & ~full;

  // Front end: decode the character, pack sextets, flush on end of text.
  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .rec_push    (rec_push),
    .rec         (wr_rec)
  );

  // Decouple the two sides: hold records until the sequencer drains them.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_rec (wr_rec),
    .full   (full),
    .rd_en  (rec_pop),
    .rd_rec (rd_rec),
    .empty  (q_empty)
  );

  // Back end: advance through each record one result per transfer.
  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec           (rd_rec),
    .rec_empty     (q_empty),
    .rec_pop       (rec_pop),
    .pop           (pop),
    .empty         (empty),
    .data_byte     (out_data_byte),
    .byte_valid    (out_byte_valid),
    .end_of_data   (out_end_of_data),
    .stopped_early (out_stopped_early)
  );

endmodule
